[hdl/jsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsd_pkg
// Shared types, sizes and helpers for the job sequencing block.
// ----------------------------------------------------------------------------
package jsd_pkg;

  localparam int MAX_JOBS   = 32;
  localparam int MAX_SLOTS  = 32;
  localparam int TAG_W      = 32;
  localparam int DL_W       = 6;
  localparam int PROFIT_W   = 20;
  localparam int SUM_W      = 25;
  localparam int CNT_W      = $clog2(MAX_JOBS + 1);
  localparam int SLOT_IDX_W = $clog2(MAX_SLOTS);

  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [DL_W-1:0]     deadline;
    logic [PROFIT_W-1:0] profit;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } cell_t;

  typedef struct packed {
    logic push;
    logic pop;
  } chain_ctl_t;

  typedef struct packed {
    logic place;
    logic clear;
  } slot_ctl_t;

  typedef enum logic [1:0] {
    S_LOAD,
    S_PLACE,
    S_EMIT
  } state_t;

  // slots 1..d as bits 0..d-1
  function automatic logic [MAX_SLOTS-1:0] low_mask(input logic [DL_W-1:0] d);
    logic [MAX_SLOTS-1:0] m;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      m[i] = (DL_W'(i) < d);
    end
    return m;
  endfunction

  function automatic logic [SLOT_IDX_W-1:0] top_bit(input logic [MAX_SLOTS-1:0] v);
    logic [SLOT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (v[i]) idx = SLOT_IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

[hdl/jsd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsd_if
// Handshake channels: job items in, slot items out.
// ----------------------------------------------------------------------------
interface jsd_job_if;
  logic                          valid;
  logic                          ready;
  logic [jsd_pkg::TAG_W-1:0]     job_tag;
  logic [jsd_pkg::DL_W-1:0]      job_deadline;
  logic [jsd_pkg::PROFIT_W-1:0]  job_profit;
  logic                          last_job;

  modport source (output valid, job_tag, job_deadline, job_profit, last_job, input ready);
  modport sink   (input valid, job_tag, job_deadline, job_profit, last_job, output ready);
endinterface

interface jsd_slot_if;
  logic                          valid;
  logic                          ready;
  logic [jsd_pkg::DL_W-1:0]      slot_number;
  logic                          slot_filled;
  logic [jsd_pkg::TAG_W-1:0]     slot_tag;
  logic [jsd_pkg::PROFIT_W-1:0]  slot_profit;
  logic [jsd_pkg::SUM_W-1:0]     total_profit;
  logic                          jobs_dropped;
  logic                          last_slot;

  modport source (output valid, slot_number, slot_filled, slot_tag, slot_profit,
                  total_profit, jobs_dropped, last_slot, input ready);
  modport sink   (input valid, slot_number, slot_filled, slot_tag, slot_profit,
                  total_profit, jobs_dropped, last_slot, output ready);
endinterface

[hdl/jsd_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsd_cell
// One sorter cell: holds a job, ordered by profit, highest at the head.
// ----------------------------------------------------------------------------
module jsd_cell (
  input  logic                clk,
  input  logic                rst,
  input  jsd_pkg::chain_ctl_t ctl,
  input  jsd_pkg::job_t       new_job,
  input  jsd_pkg::cell_t      prev_cell,
  input  logic                prev_beat,
  input  jsd_pkg::cell_t      next_cell,
  output logic                beat,
  output jsd_pkg::cell_t      held
);

  // strict compare keeps equal profits in arrival order
  assign beat = !held.valid || (new_job.profit > held.job.profit);

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (ctl.pop) begin
      held <= next_cell;
    end else if (ctl.push) begin
      if (prev_beat) begin
        held <= prev_cell;
      end else if (beat) begin
        held.valid <= 1'b1;
        held.job   <= new_job;
      end
    end
  end

endmodule

[hdl/jsd_slots.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsd_slots
// Slot table: latest free slot search, slot contents and profit total.
// ----------------------------------------------------------------------------
module jsd_slots (
  input  logic                                clk,
  input  logic                                rst,
  input  jsd_pkg::slot_ctl_t                  ctl,
  input  jsd_pkg::job_t                       job,
  input  logic [jsd_pkg::SLOT_IDX_W-1:0]      rd_idx,
  output logic                                rd_used,
  output logic [jsd_pkg::TAG_W-1:0]           rd_tag,
  output logic [jsd_pkg::PROFIT_W-1:0]        rd_profit,
  output logic [jsd_pkg::SUM_W-1:0]           sum
);

  logic [jsd_pkg::MAX_SLOTS-1:0]  used;
  logic [jsd_pkg::TAG_W-1:0]      tags    [jsd_pkg::MAX_SLOTS];
  logic [jsd_pkg::PROFIT_W-1:0]   profits [jsd_pkg::MAX_SLOTS];
  logic [jsd_pkg::MAX_SLOTS-1:0]  cand;
  logic                           hit;
  logic [jsd_pkg::SLOT_IDX_W-1:0] wr_idx;

  assign cand   = ~used & jsd_pkg::low_mask(job.deadline);
  assign hit    = |cand;
  assign wr_idx = jsd_pkg::top_bit(cand);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      used <= '0;
      sum  <= '0;
    end else if (ctl.place && hit) begin
      used[wr_idx] <= 1'b1;
      sum          <= sum + jsd_pkg::SUM_W'(job.profit);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.place && hit) begin
      tags[wr_idx]    <= job.tag;
      profits[wr_idx] <= job.profit;
    end
  end

  assign rd_used   = used[rd_idx];
  assign rd_tag    = rd_used ? tags[rd_idx] : '0;
  assign rd_profit = rd_used ? profits[rd_idx] : '0;

endmodule

[hdl/job_sequencing_with_deadlines_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// job_sequencing_with_deadlines_core
// Greedy job sequencing: sorting cell chain, slot search, slot readout.
// ----------------------------------------------------------------------------
// Jobs load one per cycle into the sorting chain, which keeps them in order.
// After the last job, placement pops each held job from the chain head into
// the slot search; then one slot item per cycle is offered unless stalled,
// max deadline items in all. Loading of the next set starts once placement
// and readout are done. Synchronous reset empties the chain and slot table.
module job_sequencing_with_deadlines_core (
  input  logic        clk,
  input  logic        rst,
  jsd_job_if.sink     job,
  jsd_slot_if.source  slot
);

  localparam int N = jsd_pkg::MAX_JOBS;

  jsd_pkg::state_t                 state, state_next;
  logic [jsd_pkg::CNT_W-1:0]       job_count;
  logic [jsd_pkg::DL_W-1:0]        max_deadline;
  logic                            overflow;
  logic [jsd_pkg::SLOT_IDX_W-1:0]  emit_idx;

  jsd_pkg::chain_ctl_t chain_ctl;
  jsd_pkg::slot_ctl_t  slot_ctl;
  jsd_pkg::job_t       new_job;
  jsd_pkg::cell_t      cells      [N];
  jsd_pkg::cell_t      prev_cells [N];
  jsd_pkg::cell_t      next_cells [N];
  logic                beats      [N];
  logic                prev_beats [N];

  logic                            accept;
  logic                            emit_load;
  logic                            emit_last;
  logic [jsd_pkg::DL_W-1:0]        emit_num;
  logic                            rd_used;
  logic [jsd_pkg::TAG_W-1:0]       rd_tag;
  logic [jsd_pkg::PROFIT_W-1:0]    rd_profit;
  logic [jsd_pkg::SUM_W-1:0]       sum;
  logic                            place_done;

  // output register
  logic                            out_valid;
  logic [jsd_pkg::DL_W-1:0]        out_num;
  logic                            out_filled;
  logic [jsd_pkg::TAG_W-1:0]       out_tag;
  logic [jsd_pkg::PROFIT_W-1:0]    out_profit;
  logic [jsd_pkg::SUM_W-1:0]       out_total;
  logic                            out_dropped;
  logic                            out_last;

  assign job.ready = (state == jsd_pkg::S_LOAD);
  assign accept    = job.valid && job.ready;

  always_comb begin
    new_job.tag      = job.job_tag;
    new_job.profit   = job.job_profit;
    new_job.deadline = (job.job_deadline > jsd_pkg::DL_W'(jsd_pkg::MAX_SLOTS))
                     ? jsd_pkg::DL_W'(jsd_pkg::MAX_SLOTS) : job.job_deadline;
  end

  // sorting chain
  for (genvar g = 0; g < N; g++) begin : g_chain
    if (g == 0) begin : g_head
      assign prev_cells[g] = '0;
      assign prev_beats[g] = 1'b0;
    end else begin : g_body
      assign prev_cells[g] = cells[g-1];
      assign prev_beats[g] = beats[g-1];
    end
    if (g == N - 1) begin : g_tail
      assign next_cells[g] = '0;
    end else begin : g_inner
      assign next_cells[g] = cells[g+1];
    end

    jsd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (chain_ctl),
      .new_job   (new_job),
      .prev_cell (prev_cells[g]),
      .prev_beat (prev_beats[g]),
      .next_cell (next_cells[g]),
      .beat      (beats[g]),
      .held      (cells[g])
    );
  end

  jsd_slots u_slots (
    .clk       (clk),
    .rst       (rst),
    .ctl       (slot_ctl),
    .job       (cells[0].job),
    .rd_idx    (emit_idx),
    .rd_used   (rd_used),
    .rd_tag    (rd_tag),
    .rd_profit (rd_profit),
    .sum       (sum)
  );

  assign place_done = !cells[0].valid;
  assign emit_load  = (state == jsd_pkg::S_EMIT) && (!out_valid || slot.ready);
  assign emit_num   = jsd_pkg::DL_W'(emit_idx) + jsd_pkg::DL_W'(1);
  assign emit_last  = (emit_num == max_deadline);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      jsd_pkg::S_LOAD: begin
        if (accept && job.last_job) state_next = jsd_pkg::S_PLACE;
      end
      jsd_pkg::S_PLACE: begin
        if (place_done) begin
          state_next = (max_deadline == '0) ? jsd_pkg::S_LOAD : jsd_pkg::S_EMIT;
        end
      end
      jsd_pkg::S_EMIT: begin
        if (emit_load && emit_last) state_next = jsd_pkg::S_LOAD;
      end
      default: state_next = jsd_pkg::S_LOAD;
    endcase
  end

  // control outputs
  always_comb begin
    chain_ctl      = '0;
    slot_ctl       = '0;
    unique case (state)
      jsd_pkg::S_LOAD: begin
        chain_ctl.push = accept && (job_count < jsd_pkg::CNT_W'(N));
      end
      jsd_pkg::S_PLACE: begin
        chain_ctl.pop  = !place_done;
        slot_ctl.place = !place_done;
        slot_ctl.clear = place_done && (max_deadline == '0);
      end
      jsd_pkg::S_EMIT: begin
        slot_ctl.clear = emit_load && emit_last;
      end
      default: begin
        chain_ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jsd_pkg::S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || slot_ctl.clear) begin
      job_count    <= '0;
      max_deadline <= '0;
      overflow     <= 1'b0;
      emit_idx     <= '0;
    end else begin
      if (chain_ctl.push) begin
        job_count <= job_count + jsd_pkg::CNT_W'(1);
        if (new_job.deadline > max_deadline) max_deadline <= new_job.deadline;
      end else if (accept) begin
        overflow <= 1'b1;
      end
      if (emit_load) emit_idx <= emit_idx + jsd_pkg::SLOT_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (slot.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_num     <= emit_num;
      out_filled  <= rd_used;
      out_tag     <= rd_tag;
      out_profit  <= rd_profit;
      out_total   <= emit_last ? sum : '0;
      out_dropped <= overflow;
      out_last    <= emit_last;
    end
  end

  assign slot.valid        = out_valid;
  assign slot.slot_number  = out_num;
  assign slot.slot_filled  = out_filled;
  assign slot.slot_tag     = out_tag;
  assign slot.slot_profit  = out_profit;
  assign slot.total_profit = out_total;
  assign slot.jobs_dropped = out_dropped;
  assign slot.last_slot    = out_last;

endmodule

[tb/sv/job_sequencing_with_deadlines_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// job_sequencing_with_deadlines_core_test
// Loads job sets into the sequencer and checks every slot item it returns.
// A scoreboard keeps its own copy of the held jobs. On each last job it ranks
// them by profit (stable), places each in the latest free slot up to its
// deadline and queues the slot items due. Directed sets cover the field
// extremes, saturated and zero deadlines, equal profits and sets that yield
// no slots. Random sets follow, some of them overflowing the store, under
// four idle/stall phases.
// ----------------------------------------------------------------------------
module job_sequencing_with_deadlines_core_test;

  localparam int RANDOM_ITEMS = 190;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int FREE_SLOT    = -1;

  typedef struct packed {
    logic [jsd_pkg::DL_W-1:0]     number;
    logic                         filled;
    logic [jsd_pkg::TAG_W-1:0]    tag;
    logic [jsd_pkg::PROFIT_W-1:0] profit;
    logic [jsd_pkg::SUM_W-1:0]    total;
    logic                         dropped;
    logic                         last;
  } slot_item_t;

  class schedule_scoreboard;
    logic [jsd_pkg::TAG_W-1:0]    held_tag [jsd_pkg::MAX_JOBS];
    logic [jsd_pkg::DL_W-1:0]     held_deadline [jsd_pkg::MAX_JOBS];
    logic [jsd_pkg::PROFIT_W-1:0] held_profit [jsd_pkg::MAX_JOBS];
    int                           held_count;
    logic [jsd_pkg::DL_W-1:0]     latest_deadline;
    logic                         overflowed;
    slot_item_t                   due_slots [$];
    int                           errors;

    function new();
      held_count      = 0;
      latest_deadline = '0;
      overflowed      = 1'b0;
      errors          = 0;
    endfunction

    function void note_job(logic [jsd_pkg::TAG_W-1:0] tag, logic [jsd_pkg::DL_W-1:0] dl,
                           logic [jsd_pkg::PROFIT_W-1:0] profit, logic last);
      logic [jsd_pkg::DL_W-1:0]  d;
      int                        rank [jsd_pkg::MAX_JOBS];
      int                        owner [jsd_pkg::MAX_SLOTS+1];
      logic [jsd_pkg::SUM_W-1:0] sum;
      int                        i, j, k, s;
      slot_item_t                item;
      d = (dl > jsd_pkg::MAX_SLOTS) ? jsd_pkg::DL_W'(jsd_pkg::MAX_SLOTS) : dl;
      if (held_count < jsd_pkg::MAX_JOBS) begin
        held_tag[held_count]      = tag;
        held_deadline[held_count] = d;
        held_profit[held_count]   = profit;
        held_count++;
        if (d > latest_deadline) latest_deadline = d;
      end else begin
        overflowed = 1'b1;
      end
      if (!last) return;
      // stable rank, highest profit first
      for (i = 0; i < held_count; i++) begin
        j = i;
        while (j > 0 && held_profit[rank[j-1]] < held_profit[i]) begin
          rank[j] = rank[j-1];
          j--;
        end
        rank[j] = i;
      end
      for (s = 0; s <= jsd_pkg::MAX_SLOTS; s++) owner[s] = FREE_SLOT;
      sum = '0;
      for (i = 0; i < held_count; i++) begin
        for (k = held_deadline[rank[i]]; k >= 1; k--) begin
          if (owner[k] == FREE_SLOT) begin
            owner[k] = rank[i];
            sum += jsd_pkg::SUM_W'(held_profit[rank[i]]);
            break;
          end
        end
      end
      for (s = 1; s <= latest_deadline; s++) begin
        item.number  = jsd_pkg::DL_W'(s);
        item.filled  = (owner[s] != FREE_SLOT);
        item.tag     = item.filled ? held_tag[owner[s]] : '0;
        item.profit  = item.filled ? held_profit[owner[s]] : '0;
        item.last    = (s == latest_deadline);
        item.total   = item.last ? sum : '0;
        item.dropped = overflowed;
        due_slots.push_back(item);
      end
      held_count      = 0;
      latest_deadline = '0;
      overflowed      = 1'b0;
    endfunction

    function void match(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_slot(slot_item_t got);
      slot_item_t want;
      if (due_slots.size() == 0) begin
        errors++;
        $display("%0t: unexpected slot item, expected none, got %p", $time, got);
        return;
      end
      want = due_slots.pop_front();
      match("slot_number", want.number, got.number);
      match("slot_filled", want.filled, got.filled);
      match("slot_tag", want.tag, got.tag);
      match("slot_profit", want.profit, got.profit);
      match("total_profit", want.total, got.total);
      match("jobs_dropped", want.dropped, got.dropped);
      match("last_slot", want.last, got.last);
    endfunction

    function int pending();
      return due_slots.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   cycle_count;

  schedule_scoreboard sb = new();

  jsd_job_if  job_if ();
  jsd_slot_if slot_if ();

  job_sequencing_with_deadlines_core dut (
    .clk  (clk),
    .rst  (rst),
    .job  (job_if),
    .slot (slot_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // slot receiver
  initial begin
    slot_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      slot_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && slot_if.valid && slot_if.ready) begin
      sb.check_slot(slot_item_t'{slot_if.slot_number, slot_if.slot_filled, slot_if.slot_tag,
                                 slot_if.slot_profit, slot_if.total_profit,
                                 slot_if.jobs_dropped, slot_if.last_slot});
    end
  end

  // valid is left high on return; the next call or a drain replaces or lowers it
  task automatic send_job(logic [jsd_pkg::TAG_W-1:0] tag, logic [jsd_pkg::DL_W-1:0] dl,
                          logic [jsd_pkg::PROFIT_W-1:0] profit, logic last);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      job_if.valid <= 1'b0;
      @(negedge clk);
    end
    job_if.valid        <= 1'b1;
    job_if.job_tag      <= tag;
    job_if.job_deadline <= dl;
    job_if.job_profit   <= profit;
    job_if.last_job     <= last;
    @(posedge clk);
    while (!job_if.ready) @(posedge clk);
    sb.note_job(tag, dl, profit, last);
  endtask

  task automatic drain();
    @(negedge clk);
    job_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic random_sets();
    int                           sent, set_no, size, j;
    logic [jsd_pkg::DL_W-1:0]     dl;
    logic [jsd_pkg::PROFIT_W-1:0] profit;
    sent   = 0;
    set_no = 0;
    while (sent < RANDOM_ITEMS) begin
      case (sent * 4 / RANDOM_ITEMS)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      if (set_no == 2)
        size = jsd_pkg::MAX_JOBS + 1;   // dropped job is the last one
      else if (set_no == 9)
        size = jsd_pkg::MAX_JOBS + 3;
      else if ($urandom_range(0, 11) == 0)
        size = $urandom_range(jsd_pkg::MAX_JOBS - 2, jsd_pkg::MAX_JOBS + 4);
      else
        size = $urandom_range(1, 8);
      for (j = 0; j < size; j++) begin
        case ($urandom_range(0, 9))
          0:       dl = '0;
          8:       dl = jsd_pkg::DL_W'($urandom_range(0, 63));
          9:       dl = jsd_pkg::DL_W'($urandom_range(24, 32));
          default: dl = jsd_pkg::DL_W'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 3))
          0:       profit = jsd_pkg::PROFIT_W'($urandom_range(0, 7));
          1:       profit = $urandom_range(0, 1) ? '1 : '0;
          default: profit = jsd_pkg::PROFIT_W'($urandom);
        endcase
        send_job($urandom, dl, profit, j == size - 1);
      end
      sent += size;
      set_no++;
    end
  endtask

  initial begin
    rst                  = 1'b1;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    job_if.valid         = 1'b0;
    job_if.job_tag       = '0;
    job_if.job_deadline  = '0;
    job_if.job_profit    = '0;
    job_if.last_job      = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // extremes, saturation, zero deadline, equal profits
    send_job(32'h0000_0000, 6'd0,  20'hFFFFF, 1'b0);
    send_job(32'hFFFF_FFFF, 6'd32, 20'h00000, 1'b0);
    send_job(32'hA5A5_A5A5, 6'd63, 20'd500,   1'b0);
    send_job(32'h5A5A_5A5A, 6'd33, 20'd500,   1'b0);
    send_job(32'h1234_5678, 6'd3,  20'hFFFFF, 1'b0);
    send_job(32'h8765_4321, 6'd1,  20'd7,     1'b1);
    // all deadlines zero: no slot items
    send_job(32'h0000_0001, 6'd0,  20'd9,     1'b0);
    send_job(32'h0000_0002, 6'd0,  20'hFFFFF, 1'b1);
    // single job
    send_job(32'hCAFE_0001, 6'd1,  20'd1,     1'b1);
    // equal profits fighting for two slots
    send_job(32'h0000_0A01, 6'd2,  20'd100,   1'b0);
    send_job(32'h0000_0A02, 6'd2,  20'd100,   1'b0);
    send_job(32'h0000_0A03, 6'd2,  20'd100,   1'b0);
    send_job(32'h0000_0A04, 6'd1,  20'd100,   1'b1);
    // mixed deadlines, last job alone with deadline zero
    send_job(32'h7FFF_FFFF, 6'd31, 20'h7FFFF, 1'b0);
    send_job(32'h8000_0000, 6'd16, 20'h80000, 1'b0);
    send_job(32'h0F0F_0F0F, 6'd31, 20'h80000, 1'b0);
    send_job(32'hF0F0_F0F0, 6'd4,  20'd3,     1'b0);
    send_job(32'h3C3C_3C3C, 6'd0,  20'h12345, 1'b1);
    drain();

    random_sets();
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

[job_sequencing_with_deadlines_core.f]
hdl/jsd_pkg.sv
hdl/jsd_if.sv
hdl/jsd_cell.sv
hdl/jsd_slots.sv
hdl/job_sequencing_with_deadlines_core.sv
tb/sv/job_sequencing_with_deadlines_core_test.sv
